/* rtl/dgpc_pkg.sv */
// ----------------------------------------------------------------------------
// dgpc_pkg
// Shared types, codes and default sizes for the dual graphic LCD page
// controller.
// ----------------------------------------------------------------------------
package dgpc_pkg;

	localparam int NUM_UNITS_DEF = 2;
	localparam int COLUMNS_DEF   = 64;
	localparam int PAGES_DEF     = 8;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] OP_READ    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_COMMAND = 2'd2;

	localparam logic [1:0] MODE_CURSOR = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_WRITE  = 2'd2;

	localparam logic [1:0] KIND_DISPLAY = 2'd0;
	localparam logic [1:0] KIND_LINE    = 2'd1;
	localparam logic [1:0] KIND_IMAGE   = 2'd2;

	localparam logic [2:0] CMD_READ    = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_COLUMN  = 3'd2;
	localparam logic [2:0] CMD_PAGE    = 3'd3;
	localparam logic [2:0] CMD_DISPLAY = 3'd4;
	localparam logic [2:0] CMD_LINE    = 3'd5;
	localparam logic [2:0] CMD_BAD     = 3'd6;

	localparam logic [7:0] MASK_COLUMN  = 8'hC0;
	localparam logic [7:0] CODE_COLUMN  = 8'h40;
	localparam logic [7:0] MASK_PAGE    = 8'hF8;
	localparam logic [7:0] CODE_PAGE    = 8'hB8;
	localparam logic [7:0] MASK_DISPLAY = 8'hFE;
	localparam logic [7:0] CODE_DISPLAY = 8'h3E;
	localparam logic [7:0] MASK_LINE    = 8'hC0;
	localparam logic [7:0] CODE_LINE    = 8'hC0;
	localparam logic [7:0] FIELD_LOW6   = 8'h3F;
	localparam logic [7:0] FIELD_LOW3   = 8'h07;
	localparam logic [7:0] FIELD_LOW1   = 8'h01;

	typedef struct packed {
		logic [1:0] operation;
		logic       controller_select;
		logic [7:0] data_byte;
	} request_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic       redraw;
		logic [1:0] redraw_kind;
		logic [6:0] screen_column;
		logic [2:0] screen_page;
		logic [7:0] changed_value;
		logic       bad_request;
	} result_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       unit;
		logic [7:0] arg;
	} cmd_t;

endpackage

/* rtl/dual_glcd_page_controller.sv */
// A taken access passes the queue slot, the stage-two registers and the result register.
// Throughput: one access per cycle while results are popped; the image RAM is read in
// the first execute stage and written in the second, with the last write forwarded.
// Reset: all controller state clears at once; the image RAM, which holds NUM_UNITS *
// 2^ceil(log2 COLUMNS) * max(2, 2^ceil(log2 PAGES)) entries (1024 by default), is then
// cleared in a pass during which full stays high.
// ----------------------------------------------------------------------------
// dual_glcd_page_controller
// Two page-addressed graphic LCD controllers behind one queue-style access port.
// ----------------------------------------------------------------------------
module dual_glcd_page_controller #(
	parameter int NUM_UNITS = dgpc_pkg::NUM_UNITS_DEF,
	parameter int COLUMNS   = dgpc_pkg::COLUMNS_DEF,
	parameter int PAGES     = dgpc_pkg::PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  dgpc_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output dgpc_pkg::result_t  result
);

	logic           queue_full;
	logic           clearing;
	logic           cmd_push;
	dgpc_pkg::cmd_t front_cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	dgpc_pkg::cmd_t back_cmd;

	dgpc_front #(
		.NUM_UNITS(NUM_UNITS),
		.COLUMNS  (COLUMNS),
		.PAGES    (PAGES)
	) u_front (
		.push       (push),
		.full       (full),
		.request    (request),
		.queue_full (queue_full),
		.clearing   (clearing),
		.cmd_push   (cmd_push),
		.cmd        (front_cmd)
	);

	dgpc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (front_cmd),
		.full   (queue_full),
		.rd_en  (cmd_pop),
		.rd_cmd (back_cmd),
		.valid  (cmd_valid)
	);

	dgpc_back #(
		.NUM_UNITS(NUM_UNITS),
		.COLUMNS  (COLUMNS),
		.PAGES    (PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.clearing  (clearing),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

/* rtl/dgpc_ram.sv */
// ----------------------------------------------------------------------------
// dgpc_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dgpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/dgpc_queue.sv */
// ----------------------------------------------------------------------------
// dgpc_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module dgpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  dgpc_pkg::cmd_t  wr_cmd,
	output logic            full,
	input  logic            rd_en,
	output dgpc_pkg::cmd_t  rd_cmd,
	output logic            valid
);

	localparam int PW = $clog2(dgpc_pkg::QUEUE_DEPTH);
	localparam int CW = $clog2(dgpc_pkg::QUEUE_DEPTH + 1);

	dgpc_pkg::cmd_t  slot_q [dgpc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(dgpc_pkg::QUEUE_DEPTH));
	assign valid  = (count_q != '0);
	assign rd_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wptr_q <= (wptr_q == PW'(dgpc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd_en) begin
				rptr_q <= (rptr_q == PW'(dgpc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/dgpc_front.sv */
// ----------------------------------------------------------------------------
// dgpc_front
// Accepts bus accesses and classifies them into commands, with the column and
// page arguments already reduced to the cursor ranges.
// ----------------------------------------------------------------------------
module dgpc_front #(
	parameter int NUM_UNITS = dgpc_pkg::NUM_UNITS_DEF,
	parameter int COLUMNS   = dgpc_pkg::COLUMNS_DEF,
	parameter int PAGES     = dgpc_pkg::PAGES_DEF
) (
	input  logic                 push,
	output logic                 full,
	input  dgpc_pkg::request_t   request,
	input  logic                 queue_full,
	input  logic                 clearing,
	output logic                 cmd_push,
	output dgpc_pkg::cmd_t       cmd
);

	localparam logic [6:0] COLS7  = 7'(COLUMNS);
	localparam logic [3:0] PAGES4 = 4'(PAGES);

	logic       unit_ok;
	logic [7:0] d;
	logic [6:0] col_v;
	logic [3:0] page_v;

	assign full     = queue_full | clearing;
	assign cmd_push = push & ~full;
	assign unit_ok  = (NUM_UNITS > 1) || !request.controller_select;
	assign d        = request.data_byte;

	always_comb begin
		col_v  = {1'b0, d[5:0]};
		page_v = 4'(d & dgpc_pkg::FIELD_LOW3);
		for (int i = 0; i < 8; i++) begin
			if (col_v >= COLS7) begin
				col_v = col_v - COLS7;
			end
			if (page_v >= PAGES4) begin
				page_v = page_v - PAGES4;
			end
		end
	end

	always_comb begin
		cmd.unit = request.controller_select;
		cmd.arg  = d;
		cmd.kind = dgpc_pkg::CMD_BAD;
		if (unit_ok) begin
			case (request.operation)
				dgpc_pkg::OP_READ: begin
					cmd.kind = dgpc_pkg::CMD_READ;
				end
				dgpc_pkg::OP_WRITE: begin
					cmd.kind = dgpc_pkg::CMD_WRITE;
				end
				dgpc_pkg::OP_COMMAND: begin
					if ((d & dgpc_pkg::MASK_COLUMN) == dgpc_pkg::CODE_COLUMN) begin
						cmd.kind = dgpc_pkg::CMD_COLUMN;
						cmd.arg  = {1'b0, col_v};
					end else if ((d & dgpc_pkg::MASK_PAGE) == dgpc_pkg::CODE_PAGE) begin
						cmd.kind = dgpc_pkg::CMD_PAGE;
						cmd.arg  = {4'd0, page_v};
					end else if ((d & dgpc_pkg::MASK_DISPLAY) == dgpc_pkg::CODE_DISPLAY) begin
						cmd.kind = dgpc_pkg::CMD_DISPLAY;
						cmd.arg  = d & dgpc_pkg::FIELD_LOW1;
					end else if ((d & dgpc_pkg::MASK_LINE) == dgpc_pkg::CODE_LINE) begin
						cmd.kind = dgpc_pkg::CMD_LINE;
						cmd.arg  = d & dgpc_pkg::FIELD_LOW6;
					end
				end
				default: begin
					cmd.kind = dgpc_pkg::CMD_BAD;
				end
			endcase
		end
	end

endmodule

/* rtl/dgpc_back.sv */
// ----------------------------------------------------------------------------
// dgpc_back
// Executes commands in two stages around the image RAM, keeps the
// per-controller state and holds the result register.
// ----------------------------------------------------------------------------
module dgpc_back #(
	parameter int NUM_UNITS = dgpc_pkg::NUM_UNITS_DEF,
	parameter int COLUMNS   = dgpc_pkg::COLUMNS_DEF,
	parameter int PAGES     = dgpc_pkg::PAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  dgpc_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               clearing,
	output logic               empty,
	input  logic               pop,
	output dgpc_pkg::result_t  result
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int UIW   = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int DEPTH = NUM_UNITS << (CW + PW);
	localparam int AW    = $clog2(DEPTH);

	logic [1:0]    mode_q  [NUM_UNITS];
	logic          disp_q  [NUM_UNITS];
	logic [CW-1:0] col_q   [NUM_UNITS];
	logic [PW-1:0] page_q  [NUM_UNITS];
	logic [5:0]    line_q  [NUM_UNITS];
	logic [7:0]    latch_q [NUM_UNITS];

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          a_go;
	logic [UIW-1:0] ua;
	logic [AW-1:0] a_addr;
	logic [CW-1:0] col_next;
	logic          a_load;
	logic          a_redraw;
	logic [1:0]    a_rkind;
	logic [7:0]    a_val;

	logic          v_s2;
	logic [2:0]    kind_s2;
	logic [UIW-1:0] unit_s2;
	logic          load_s2;
	logic [AW-1:0] addr_s2;
	logic [7:0]    data_s2;
	logic [6:0]    scol_s2;
	logic [2:0]    spage_s2;
	logic          redraw_s2;
	logic [1:0]    rkind_s2;
	logic [7:0]    val_s2;

	logic          fwd_v_q;
	logic [AW-1:0] fwd_addr_q;
	logic [7:0]    fwd_data_q;

	logic [7:0]    ram_rdata;
	logic [7:0]    img;
	logic          b_adv;
	logic          b_write;
	dgpc_pkg::result_t res;

	logic          out_v_q;
	dgpc_pkg::result_t out_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;

	assign clearing = clr_busy_q;
	assign empty    = ~out_v_q;
	assign result   = out_q;

	assign b_adv   = v_s2 & (~out_v_q | pop);
	assign a_go    = cmd_valid & (~v_s2 | b_adv);
	assign cmd_pop = a_go;

	assign ua       = UIW'(cmd.unit);
	assign a_addr   = AW'({ua, col_q[ua], page_q[ua]});
	assign col_next = (col_q[ua] >= CW'(COLUMNS - 1)) ? '0 : col_q[ua] + 1'b1;

	always_comb begin
		a_load   = 1'b0;
		a_redraw = 1'b0;
		a_rkind  = dgpc_pkg::KIND_DISPLAY;
		a_val    = '0;
		case (cmd.kind)
			dgpc_pkg::CMD_READ: begin
				a_load = (mode_q[ua] == dgpc_pkg::MODE_READ);
			end
			dgpc_pkg::CMD_DISPLAY: begin
				if (disp_q[ua] != cmd.arg[0]) begin
					a_redraw = 1'b1;
					a_rkind  = dgpc_pkg::KIND_DISPLAY;
					a_val    = cmd.arg;
				end
			end
			dgpc_pkg::CMD_LINE: begin
				if (line_q[ua] != cmd.arg[5:0]) begin
					a_redraw = 1'b1;
					a_rkind  = dgpc_pkg::KIND_LINE;
					a_val    = cmd.arg;
				end
			end
			default: begin
				a_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_UNITS; i++) begin
				mode_q[i]  <= dgpc_pkg::MODE_CURSOR;
				disp_q[i]  <= 1'b0;
				col_q[i]   <= '0;
				page_q[i]  <= '0;
				line_q[i]  <= '0;
				latch_q[i] <= '0;
			end
		end else begin
			if (a_go) begin
				case (cmd.kind)
					dgpc_pkg::CMD_READ: begin
						if (a_load) begin
							col_q[ua] <= col_next;
						end
						mode_q[ua] <= dgpc_pkg::MODE_READ;
					end
					dgpc_pkg::CMD_WRITE: begin
						col_q[ua]  <= col_next;
						mode_q[ua] <= dgpc_pkg::MODE_WRITE;
					end
					dgpc_pkg::CMD_COLUMN: begin
						col_q[ua]  <= cmd.arg[CW-1:0];
						mode_q[ua] <= dgpc_pkg::MODE_CURSOR;
					end
					dgpc_pkg::CMD_PAGE: begin
						page_q[ua] <= cmd.arg[PW-1:0];
						mode_q[ua] <= dgpc_pkg::MODE_CURSOR;
					end
					dgpc_pkg::CMD_DISPLAY: begin
						disp_q[ua] <= cmd.arg[0];
					end
					dgpc_pkg::CMD_LINE: begin
						line_q[ua] <= cmd.arg[5:0];
					end
					default: begin
						mode_q[ua] <= mode_q[ua];
					end
				endcase
			end
			if (b_adv && load_s2) begin
				latch_q[unit_s2] <= img;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (a_go) begin
			kind_s2   <= cmd.kind;
			unit_s2   <= ua;
			load_s2   <= a_load;
			addr_s2   <= a_addr;
			data_s2   <= cmd.arg;
			scol_s2   <= 7'(col_q[ua]) + (cmd.unit ? 7'(COLUMNS) : 7'd0);
			spage_s2  <= 3'(page_q[ua]);
			redraw_s2 <= a_redraw;
			rkind_s2  <= a_rkind;
			val_s2    <= a_val;
		end
	end

	dgpc_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_image (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (a_go),
		.raddr (a_addr),
		.rdata (ram_rdata)
	);

	assign img       = (fwd_v_q && fwd_addr_q == addr_s2) ? fwd_data_q : ram_rdata;
	assign b_write   = b_adv && kind_s2 == dgpc_pkg::CMD_WRITE && img != data_s2;
	assign ram_we    = clr_busy_q | b_write;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clr_busy_q ? 8'd0 : data_s2;

	always_comb begin
		res = '0;
		case (kind_s2)
			dgpc_pkg::CMD_READ: begin
				res.read_value = load_s2 ? img : latch_q[unit_s2];
			end
			dgpc_pkg::CMD_WRITE: begin
				if (img != data_s2) begin
					res.redraw        = 1'b1;
					res.redraw_kind   = dgpc_pkg::KIND_IMAGE;
					res.screen_column = scol_s2;
					res.screen_page   = spage_s2;
					res.changed_value = data_s2;
				end
			end
			dgpc_pkg::CMD_DISPLAY, dgpc_pkg::CMD_LINE: begin
				res.redraw        = redraw_s2;
				res.redraw_kind   = rkind_s2;
				res.changed_value = val_s2;
			end
			dgpc_pkg::CMD_BAD: begin
				res.bad_request = 1'b1;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			fwd_v_q    <= 1'b0;
			v_s2       <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (b_write) begin
				fwd_v_q <= 1'b1;
			end
			if (a_go) begin
				v_s2 <= 1'b1;
			end else if (b_adv) begin
				v_s2 <= 1'b0;
			end
			if (b_adv) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b_write) begin
			fwd_addr_q <= addr_s2;
			fwd_data_q <= data_s2;
		end
		if (b_adv) begin
			out_q <= res;
		end
	end

endmodule
